FILE: sv/i2cm_pkg.sv
// Shared types and constants for the I2C register access master.
package i2cm_pkg;

  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_WRITE = 2'd2;
  localparam logic [1:0] KIND_LOAD  = 2'd3;

  localparam logic [7:0] ACK_TIMEOUT_RST = 8'd250;

  typedef enum logic [21:0] {
    PH_IDLE      = 22'd1 << 0,
    PH_START_A   = 22'd1 << 1,
    PH_START_B   = 22'd1 << 2,
    PH_TX_LOW    = 22'd1 << 3,
    PH_TX_SET    = 22'd1 << 4,
    PH_TX_HIGH   = 22'd1 << 5,
    PH_ACK_LOW   = 22'd1 << 6,
    PH_ACK_REL   = 22'd1 << 7,
    PH_ACK_HIGH  = 22'd1 << 8,
    PH_ACK_CHECK = 22'd1 << 9,
    PH_RS_LOW    = 22'd1 << 10,
    PH_RS_REL    = 22'd1 << 11,
    PH_RX_LOW    = 22'd1 << 12,
    PH_RX_REL    = 22'd1 << 13,
    PH_RX_HIGH   = 22'd1 << 14,
    PH_RA_LOW    = 22'd1 << 15,
    PH_RA_SET    = 22'd1 << 16,
    PH_RA_HIGH   = 22'd1 << 17,
    PH_STOP_LOW  = 22'd1 << 18,
    PH_STOP_SET  = 22'd1 << 19,
    PH_STOP_RISE = 22'd1 << 20,
    PH_STOP_END  = 22'd1 << 21
  } phase_t;

  typedef enum logic [1:0] {
    STG_ADDR_W = 2'd0,
    STG_REG    = 2'd1,
    STG_ADDR_R = 2'd2,
    STG_DATA   = 2'd3
  } stage_t;

  // One classified item passed from the front to the back.
  typedef struct packed {
    logic [1:0] kind;
    logic       sda;
    logic [6:0] dev_addr;
    logic [7:0] reg_addr;
    logic [7:0] count;
    logic [7:0] write_byte;
  } item_t;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic [7:0] read_data;
    logic       read_valid;
    logic       busy;
    logic       done;
    logic       ack_failed;
  } result_t;

endpackage

FILE: sv/i2cm_front.sv
// Input side: unpacks items and holds them in a short queue for the sequencer.
module i2cm_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [33:0]          in_data,
  output logic                 q_valid,
  input  logic                 q_ready,
  output i2cm_pkg::item_t      q_item
);

  i2cm_pkg::item_t mem_r [2];
  logic            wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]      cnt_r, cnt_nxt;
  logic            push, pop;
  i2cm_pkg::item_t it;

  assign it.kind       = in_data[1:0];
  assign it.sda        = in_data[2];
  assign it.dev_addr   = in_data[9:3];
  assign it.reg_addr   = in_data[17:10];
  assign it.count      = in_data[25:18];
  assign it.write_byte = in_data[33:26];

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = mem_r[rp_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_comb begin
    wp_nxt  = wp_r ^ push;
    rp_nxt  = rp_r ^ pop;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= it;
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

FILE: sv/i2cm_back.sv
// Bus sequencer: executes queued items and registers one result per item.
module i2cm_back #(
  parameter int WRITE_DEPTH = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [7:0]           ack_timeout,
  input  logic                 q_valid,
  output logic                 q_ready,
  input  i2cm_pkg::item_t      q_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output i2cm_pkg::result_t    out_res
);

  localparam int CW = $clog2(WRITE_DEPTH + 1);
  localparam int AW = (WRITE_DEPTH > 1) ? $clog2(WRITE_DEPTH) : 1;
  // The byte counter serves both the write buffer and read counts up to 255.
  localparam int BW = (CW > 8) ? CW : 8;

  i2cm_pkg::phase_t  phase_r, phase_nxt;
  i2cm_pkg::stage_t  stage_r, stage_nxt;
  logic [3:0]        bit_r, bit_nxt;
  logic [7:0]        shift_r, shift_nxt;
  logic [BW-1:0]     byte_r, byte_nxt;
  logic [7:0]        wait_r, wait_nxt;
  logic [CW-1:0]     loaded_r, loaded_nxt;
  logic [23:0]       cmd_r, cmd_nxt;
  logic              scl_r, scl_nxt, sda_r, sda_nxt;
  logic              fail_r, fail_nxt;
  logic [7:0]        wbuf_r [WRITE_DEPTH];
  logic [7:0]        wbuf_rd_r;
  logic [AW-1:0]     rd_addr;
  logic              take, buf_we;
  i2cm_pkg::result_t res_nxt, res_r;
  logic              ov_r;
  logic [BW-1:0]     byte_inc;
  logic [8:0]        ra_next;

  // Result register frees as soon as the downstream takes it.
  assign q_ready   = !ov_r || out_ready;
  assign take      = q_valid && q_ready;
  assign out_valid = ov_r;
  assign out_res   = res_r;
  assign byte_inc  = byte_r + 1'b1;
  assign ra_next   = 9'(byte_r) + 9'd1;

  // The buffer entry the sequencer will need at the next acknowledge is
  // fetched into a register every cycle. Its address only moves at an
  // acknowledge, and a whole byte of bus steps passes before the next one,
  // so the fetched entry is always current when it is used.
  assign rd_addr = (stage_r == i2cm_pkg::STG_DATA) ? byte_inc[AW-1:0] : '0;

  always_comb begin
    phase_nxt  = phase_r;
    stage_nxt  = stage_r;
    bit_nxt    = bit_r;
    shift_nxt  = shift_r;
    byte_nxt   = byte_r;
    wait_nxt   = wait_r;
    loaded_nxt = loaded_r;
    cmd_nxt    = cmd_r;
    scl_nxt    = scl_r;
    sda_nxt    = sda_r;
    fail_nxt   = fail_r;
    buf_we     = 1'b0;
    res_nxt    = '0;
    if (q_item.kind == i2cm_pkg::KIND_READ || q_item.kind == i2cm_pkg::KIND_WRITE) begin
      if (phase_r == i2cm_pkg::PH_IDLE) begin
        cmd_nxt   = {q_item.kind == i2cm_pkg::KIND_READ, q_item.dev_addr,
                     q_item.reg_addr, q_item.count};
        stage_nxt = i2cm_pkg::STG_ADDR_W;
        byte_nxt  = '0;
        bit_nxt   = '0;
        shift_nxt = '0;
        wait_nxt  = '0;
        fail_nxt  = 1'b0;
        phase_nxt = i2cm_pkg::PH_START_A;
      end
    end else if (q_item.kind == i2cm_pkg::KIND_LOAD) begin
      if (phase_r == i2cm_pkg::PH_IDLE && loaded_r < CW'(WRITE_DEPTH)) begin
        buf_we     = 1'b1;
        loaded_nxt = loaded_r + 1'b1;
      end
    end else begin
      unique case (phase_r)
        i2cm_pkg::PH_IDLE: begin
          scl_nxt = scl_r;
          sda_nxt = sda_r;
        end
        i2cm_pkg::PH_START_A: begin
          scl_nxt = 1'b1; sda_nxt = 1'b1; phase_nxt = i2cm_pkg::PH_START_B;
        end
        i2cm_pkg::PH_START_B: begin
          scl_nxt   = 1'b1; sda_nxt = 1'b0;
          shift_nxt = {cmd_r[22:16], stage_r == i2cm_pkg::STG_ADDR_R};
          bit_nxt   = '0;
          phase_nxt = i2cm_pkg::PH_TX_LOW;
        end
        i2cm_pkg::PH_TX_LOW: begin
          scl_nxt = 1'b0; phase_nxt = i2cm_pkg::PH_TX_SET;
        end
        i2cm_pkg::PH_TX_SET: begin
          scl_nxt = 1'b0; sda_nxt = shift_r[7]; phase_nxt = i2cm_pkg::PH_TX_HIGH;
        end
        i2cm_pkg::PH_TX_HIGH: begin
          scl_nxt   = 1'b1; sda_nxt = shift_r[7];
          shift_nxt = {shift_r[6:0], 1'b0};
          bit_nxt   = bit_r + 4'd1;
          phase_nxt = (bit_r == 4'd7) ? i2cm_pkg::PH_ACK_LOW : i2cm_pkg::PH_TX_LOW;
        end
        i2cm_pkg::PH_ACK_LOW: begin
          scl_nxt = 1'b0; phase_nxt = i2cm_pkg::PH_ACK_REL;
        end
        i2cm_pkg::PH_ACK_REL: begin
          scl_nxt = 1'b0; sda_nxt = 1'b1; phase_nxt = i2cm_pkg::PH_ACK_HIGH;
        end
        i2cm_pkg::PH_ACK_HIGH: begin
          scl_nxt = 1'b1; sda_nxt = 1'b1; wait_nxt = '0;
          phase_nxt = i2cm_pkg::PH_ACK_CHECK;
        end
        i2cm_pkg::PH_ACK_CHECK: begin
          scl_nxt = 1'b1; sda_nxt = 1'b1;
          if (!q_item.sda) begin
            unique case (stage_r)
              i2cm_pkg::STG_ADDR_W: begin
                stage_nxt = i2cm_pkg::STG_REG;
                shift_nxt = cmd_r[15:8];
                bit_nxt   = '0;
                phase_nxt = i2cm_pkg::PH_TX_LOW;
              end
              i2cm_pkg::STG_REG: begin
                if (cmd_r[23]) begin
                  stage_nxt = i2cm_pkg::STG_ADDR_R;
                  phase_nxt = i2cm_pkg::PH_RS_LOW;
                end else if (loaded_r != '0) begin
                  stage_nxt = i2cm_pkg::STG_DATA;
                  byte_nxt  = '0;
                  shift_nxt = wbuf_rd_r;
                  bit_nxt   = '0;
                  phase_nxt = i2cm_pkg::PH_TX_LOW;
                end else begin
                  phase_nxt = i2cm_pkg::PH_STOP_LOW;
                end
              end
              i2cm_pkg::STG_ADDR_R: begin
                if (cmd_r[7:0] == 8'd0) begin
                  phase_nxt = i2cm_pkg::PH_STOP_LOW;
                end else begin
                  byte_nxt  = '0;
                  bit_nxt   = '0;
                  shift_nxt = '0;
                  phase_nxt = i2cm_pkg::PH_RX_LOW;
                end
              end
              default: begin
                byte_nxt = byte_inc;
                if (byte_inc < BW'(loaded_r)) begin
                  shift_nxt = wbuf_rd_r;
                  bit_nxt   = '0;
                  phase_nxt = i2cm_pkg::PH_TX_LOW;
                end else begin
                  phase_nxt = i2cm_pkg::PH_STOP_LOW;
                end
              end
            endcase
          end else if (wait_r >= ack_timeout) begin
            fail_nxt  = 1'b1;
            phase_nxt = i2cm_pkg::PH_STOP_LOW;
          end else begin
            wait_nxt = wait_r + 8'd1;
          end
        end
        i2cm_pkg::PH_RS_LOW: begin
          scl_nxt = 1'b0; phase_nxt = i2cm_pkg::PH_RS_REL;
        end
        i2cm_pkg::PH_RS_REL: begin
          scl_nxt = 1'b0; sda_nxt = 1'b1; phase_nxt = i2cm_pkg::PH_START_A;
        end
        i2cm_pkg::PH_RX_LOW: begin
          scl_nxt = 1'b0; phase_nxt = i2cm_pkg::PH_RX_REL;
        end
        i2cm_pkg::PH_RX_REL: begin
          scl_nxt = 1'b0; sda_nxt = 1'b1; phase_nxt = i2cm_pkg::PH_RX_HIGH;
        end
        i2cm_pkg::PH_RX_HIGH: begin
          scl_nxt   = 1'b1; sda_nxt = 1'b1;
          shift_nxt = {shift_r[6:0], q_item.sda};
          bit_nxt   = bit_r + 4'd1;
          if (bit_r == 4'd7) begin
            res_nxt.read_valid = 1'b1;
            res_nxt.read_data  = {shift_r[6:0], q_item.sda};
            phase_nxt = i2cm_pkg::PH_RA_LOW;
          end else begin
            phase_nxt = i2cm_pkg::PH_RX_LOW;
          end
        end
        i2cm_pkg::PH_RA_LOW: begin
          scl_nxt = 1'b0; phase_nxt = i2cm_pkg::PH_RA_SET;
        end
        i2cm_pkg::PH_RA_SET: begin
          scl_nxt   = 1'b0;
          sda_nxt   = (ra_next >= {1'b0, cmd_r[7:0]});
          phase_nxt = i2cm_pkg::PH_RA_HIGH;
        end
        i2cm_pkg::PH_RA_HIGH: begin
          scl_nxt  = 1'b1;
          byte_nxt = byte_inc;
          if (ra_next >= {1'b0, cmd_r[7:0]}) begin
            phase_nxt = i2cm_pkg::PH_STOP_LOW;
          end else begin
            bit_nxt   = '0;
            shift_nxt = '0;
            phase_nxt = i2cm_pkg::PH_RX_LOW;
          end
        end
        i2cm_pkg::PH_STOP_LOW: begin
          scl_nxt = 1'b0; phase_nxt = i2cm_pkg::PH_STOP_SET;
        end
        i2cm_pkg::PH_STOP_SET: begin
          scl_nxt = 1'b0; sda_nxt = 1'b0; phase_nxt = i2cm_pkg::PH_STOP_RISE;
        end
        i2cm_pkg::PH_STOP_RISE: begin
          scl_nxt = 1'b1; sda_nxt = 1'b0; phase_nxt = i2cm_pkg::PH_STOP_END;
        end
        i2cm_pkg::PH_STOP_END: begin
          scl_nxt = 1'b1; sda_nxt = 1'b1;
          res_nxt.done       = 1'b1;
          res_nxt.ack_failed = fail_r;
          if (!cmd_r[23]) loaded_nxt = '0;
          fail_nxt  = 1'b0;
          phase_nxt = i2cm_pkg::PH_IDLE;
        end
        default: begin
          scl_nxt = 1'b1; sda_nxt = 1'b1; phase_nxt = i2cm_pkg::PH_IDLE;
        end
      endcase
    end
    res_nxt.scl  = scl_nxt;
    res_nxt.sda  = sda_nxt;
    res_nxt.busy = (phase_nxt != i2cm_pkg::PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (take && buf_we) begin
      wbuf_r[loaded_r[AW-1:0]] <= q_item.write_byte;
    end
    wbuf_rd_r <= wbuf_r[rd_addr];
    if (take) begin
      res_r   <= res_nxt;
      shift_r <= shift_nxt;
    end
    if (!rst_n) begin
      phase_r  <= i2cm_pkg::PH_IDLE;
      stage_r  <= i2cm_pkg::STG_ADDR_W;
      bit_r    <= '0;
      byte_r   <= '0;
      wait_r   <= '0;
      loaded_r <= '0;
      scl_r    <= 1'b1;
      sda_r    <= 1'b1;
      fail_r   <= 1'b0;
      ov_r     <= 1'b0;
      cmd_r    <= '0;
    end else begin
      if (take) begin
        phase_r  <= phase_nxt;
        stage_r  <= stage_nxt;
        bit_r    <= bit_nxt;
        byte_r   <= byte_nxt;
        wait_r   <= wait_nxt;
        loaded_r <= loaded_nxt;
        scl_r    <= scl_nxt;
        sda_r    <= sda_nxt;
        fail_r   <= fail_nxt;
        cmd_r    <= cmd_nxt;
      end
      if (take) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
    end
  end

endmodule

FILE: sv/i2c_master_register_access_core.sv
// Top level of the I2C register access master with its configuration port.
//
// Usage: every input item is either a bus tick (kind 0, carrying the sampled
// SDA level), a begin-read or begin-write command, or a write-buffer load.
// The kind travels on in_tuser, the other fields on in_tdata.
// Each accepted item yields exactly one result item carrying the SCL and SDA
// drive levels, any received byte, and busy, done and ack_failed flags.
// The sequencer advances one small step per tick, so the caller paces ticks
// at the desired bus delay unit and drives the pins from scl_out/sda_out.
// Throughput is one item per cycle while the receiver accepts results. An
// item enters a two-entry queue; the sequencer takes it once its result
// register is free and registers the result for the output channel. The
// sequencer does one state step per accepted item and fetches the next
// write-buffer byte ahead into a register, so no other stall arises.
// When the receiver stalls, the result register holds and the queue fills;
// in_tready falls only when both queue entries are occupied.
// Reset puts the sequencer in idle with both lines released, empties the
// write buffer count and the queue, and sets ack_timeout to 250.
// The configuration register ack_timeout sits at byte address 0.
module i2c_master_register_access_core #(
  parameter int WRITE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // sda_in[0], dev_addr[7:1], reg_addr[15:8], count[23:16], write_byte[31:24].
  input  logic [31:0] in_tdata,
  // kind[1:0].
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // scl_out[0], sda_out[1], read_data[9:2], read_valid[10], busy_res[11],
  // ack_failed[12], zero fill to 16 bits.
  output logic [15:0] out_tdata,
  // done_res, which marks the end of a transaction.
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [7:0]          timeout_r;
  logic                q_valid, q_ready;
  i2cm_pkg::item_t     q_item;
  i2cm_pkg::result_t   res;

  assign cfg_pready    = 1'b1;
  assign cfg_prdata    = (cfg_paddr == 2'd0) ? {24'd0, timeout_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= i2cm_pkg::ACK_TIMEOUT_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == 2'd0) begin
      timeout_r <= cfg_pwdata[7:0];
    end
  end

  i2cm_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_data  ({in_tdata, in_tuser}),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item)
  );

  i2cm_back #(.WRITE_DEPTH(WRITE_DEPTH)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .ack_timeout (timeout_r),
    .q_valid     (q_valid),
    .q_ready     (q_ready),
    .q_item      (q_item),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_res     (res)
  );

  assign out_tdata = {3'd0, res.ack_failed, res.busy, res.read_valid,
                      res.read_data, res.sda, res.scl};
  assign out_tlast = res.done;

endmodule
